// ----- rtl/core/tefs_pkg.sv -----
// Shared types, codes and constants of the timestamped event frame scheduler.
package tefs_pkg;

  localparam int TEFS_TABLE_DEPTH      = 256;
  localparam int TEFS_FRAME_EVENTS_MAX = 32;

  localparam int TIME_W = 48;
  localparam int KIND_W = 3;
  localparam int NOTE_W = 7;
  localparam int OFF_W  = 12;
  localparam int FLEN_W = 13;

  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST = FLEN_W'(256);
  localparam logic [TIME_W-1:0] OFF_MAX          = TIME_W'(4095);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NONE_DUE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] event_time;
    logic [KIND_W-1:0] event_kind;
    logic [NOTE_W-1:0] event_note;
    logic [TIME_W-1:0] frame_start;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [KIND_W-1:0] out_kind;
    logic [NOTE_W-1:0] out_note;
    logic [TIME_W-1:0] out_time;
    logic [OFF_W-1:0]  sample_offset;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note;
  } entry_t;

endpackage

// ----- rtl/core/tefs_table.sv -----
// Pending event table: one write port, two registered read ports.
module tefs_table
  import tefs_pkg::*;
#(
  parameter int TABLE_DEPTH = TEFS_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output entry_t        rdata_a,
  output entry_t        rdata_b
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/tefs_ctrl.sv -----
// Command sequencer: push into the table, frame scan with swap-remove, result register.
module tefs_ctrl
  import tefs_pkg::*;
#(
  parameter int TABLE_DEPTH      = TEFS_TABLE_DEPTH,
  parameter int FRAME_EVENTS_MAX = TEFS_FRAME_EVENTS_MAX,
  parameter int AW               = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  input  logic [FLEN_W-1:0] frame_length,
  output logic              out_valid,
  output out_t              out_data,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output entry_t            mem_wdata,
  output logic [AW-1:0]     mem_raddr_a,
  output logic [AW-1:0]     mem_raddr_b,
  input  entry_t            mem_rdata_a,
  input  entry_t            mem_rdata_b
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $clog2(FRAME_EVENTS_MAX + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ix_r, ix_nxt;
  logic [EW-1:0]     nrel_r, nrel_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  out_t              hold_r, hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              accept;
  logic              scan_more;
  logic              due;
  logic [TIME_W-1:0] off_raw;
  logic [OFF_W-1:0]  off_sat;
  logic [CW-1:0]     count_m1;

  assign accept    = start && (state_r == S_IDLE);
  assign scan_more = (ix_r < count_r) && (nrel_r < EW'(FRAME_EVENTS_MAX));
  assign count_m1  = count_r - CW'(1);

  // Stale events count as offset zero.
  assign off_raw = (mem_rdata_a.ev_time > start_r) ? (mem_rdata_a.ev_time - start_r) : '0;
  assign due     = off_raw < {{(TIME_W-FLEN_W){1'b0}}, frame_length};
  assign off_sat = (off_raw > OFF_MAX) ? OFF_MAX[OFF_W-1:0] : off_raw[OFF_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.cmd == CMD_FRAME)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = scan_more ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        state_nxt = S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    ix_nxt         = ix_r;
    nrel_nxt       = nrel_r;
    start_nxt      = start_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = '{ev_time: in_data.event_time, kind: in_data.event_kind,
                       note: in_data.event_note};
    mem_raddr_a    = ix_r[AW-1:0];
    mem_raddr_b    = count_m1[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_PUSH) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.last  = 1'b1;
            if (count_r < CW'(TABLE_DEPTH)) begin
              mem_we         = 1'b1;
              count_nxt      = count_r + CW'(1);
              out_nxt.status = ST_PUSH_OK;
            end else begin
              out_nxt.status = ST_PUSH_FULL;
            end
          end else begin
            start_nxt      = in_data.frame_start;
            ix_nxt         = '0;
            nrel_nxt       = '0;
            hold_valid_nxt = 1'b0;
          end
        end
      end
      S_READ: begin
        // Scan over: flush the held release as final, or report nothing due.
        if (!scan_more) begin
          out_valid_nxt = 1'b1;
          if (hold_valid_r) begin
            out_nxt      = hold_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt        = '0;
            out_nxt.status = ST_NONE_DUE;
            out_nxt.last   = 1'b1;
          end
          hold_valid_nxt = 1'b0;
        end
      end
      S_EVAL: begin
        if (due) begin
          // Swap-remove: move the tail entry into this slot and rescan the slot.
          mem_we                 = 1'b1;
          mem_waddr              = ix_r[AW-1:0];
          mem_wdata              = mem_rdata_b;
          count_nxt              = count_m1;
          nrel_nxt               = nrel_r + EW'(1);
          out_valid_nxt          = hold_valid_r;
          out_nxt                = hold_r;
          out_nxt.last           = 1'b0;
          hold_valid_nxt         = 1'b1;
          hold_nxt.status        = ST_RELEASED;
          hold_nxt.out_kind      = mem_rdata_a.kind;
          hold_nxt.out_note      = mem_rdata_a.note;
          hold_nxt.out_time      = mem_rdata_a.ev_time;
          hold_nxt.sample_offset = off_sat;
          hold_nxt.last          = 1'b0;
        end else begin
          ix_nxt = ix_r + CW'(1);
        end
      end
      default: begin
        hold_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ix_r    <= ix_nxt;
    nrel_r  <= nrel_nxt;
    start_r <= start_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/timestamped_event_frame_scheduler_core.sv -----
// Top level of the timestamped event frame scheduler.
// A push transaction's result (accepted or table full) appears on the cycle
// after start. A frame transaction scans the pending table from index 0;
// each examined entry passes through a table read state (S_READ, the
// registered read) and a compare state with optional swap-remove (S_EVAL).
// busy stays high while the scan runs, and no new start is accepted until it
// falls; the final result of a frame shows in the cycle busy falls. The scan
// stops early after FRAME_EVENTS_MAX releases. Each released event is shown
// one release behind, so last can be marked on the final one. Results are
// strobed by out_valid for one cycle and cannot be held off. The table needs
// no clearing after reset.
// Write cfg_wr_data (frame length) only while busy is low and no result is
// outstanding.
module timestamped_event_frame_scheduler_core
  import tefs_pkg::*;
#(
  parameter int TABLE_DEPTH      = TEFS_TABLE_DEPTH,
  parameter int FRAME_EVENTS_MAX = TEFS_FRAME_EVENTS_MAX
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [FLEN_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [FLEN_W-1:0] frame_length_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr_a;
  logic [AW-1:0]     mem_raddr_b;
  entry_t            mem_rdata_a;
  entry_t            mem_rdata_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LENGTH_RST;
    end else if (cfg_wr_en) begin
      frame_length_r <= cfg_wr_data;
    end
  end

  tefs_ctrl #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .FRAME_EVENTS_MAX (FRAME_EVENTS_MAX),
    .AW               (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .frame_length (frame_length_r),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr_a  (mem_raddr_a),
    .mem_raddr_b  (mem_raddr_b),
    .mem_rdata_a  (mem_rdata_a),
    .mem_rdata_b  (mem_rdata_b)
  );

  tefs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule

// ----- rtl/core/tefs_checker.sv -----
// Port-level checks of the scheduler, bound to the top level.
module tefs_checker
  import tefs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // Every result follows an accepted transaction or a running scan.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a transaction in flight");

  // A push answers on the next cycle with a single final result.
  a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cmd == CMD_PUSH)) |=>
      (out_valid && out_data.last &&
       ((out_data.status == ST_PUSH_OK) || (out_data.status == ST_PUSH_FULL))))
    else $error("push transaction not answered next cycle");

  // A frame transaction starts a scan.
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cmd == CMD_FRAME)) |=> busy)
    else $error("frame transaction did not start a scan");

  // The end of a scan shows the final result of the frame.
  a_scan_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && out_data.last))
    else $error("scan ended without a final result");

  // Only released events can be non-final results.
  a_nonlast_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.status == ST_RELEASED))
    else $error("non-final result that is not a release");

endmodule

bind timestamped_event_frame_scheduler_core tefs_checker u_tefs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
